FILE: src/rhlc_pkg.sv
// Shared constants and controller/datapath interface types for the region
// handle LRU cache. Used by rhlc_ctrl, rhlc_dpath and the top level.
package rhlc_pkg;

  localparam int SLOTS        = 16;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REGION_SHIFT = 5;
  localparam int STAMP_BITS   = 32;

  localparam int CHUNK_W      = 22;
  localparam int REGION_W     = 17;
  localparam int KEY_W        = 2 * REGION_W;
  localparam int SLOT_FIELD_W = 4;

  // Word layouts on the two stream channels.
  localparam int IN_FIELDS_W  = 2 * CHUNK_W + 2;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 + SLOT_FIELD_W + 4 * REGION_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the request word and reset the scan
    logic step;    // examine one slot
    logic commit;  // update the table and the use counter
    logic load;    // load the result word into the output register
  } rhlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the slot being examined is the last one
  } rhlc_sts_t;

endpackage

FILE: src/rhlc_ctrl.sv
// Sequencing state machine of the region handle LRU cache.
// Depends on rhlc_pkg for the command and status types.
module rhlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rhlc_pkg::rhlc_cmd_t cmd,
  input  rhlc_pkg::rhlc_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    cmd.start   = 1'b0;
    cmd.step    = 1'b0;
    cmd.commit  = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  a_scan_ends_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && sts.scan_last |=> (state_r == ST_COMMIT))
    else $error("scan of the last slot did not lead to commit");

  a_out_held_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn before it was taken");
`endif

endmodule

FILE: src/rhlc_dpath.sv
// Datapath of the region handle LRU cache: slot table, use counter, the
// per-slot scan registers and the output word register. Depends on rhlc_pkg.
module rhlc_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [rhlc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic [rhlc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  rhlc_pkg::rhlc_cmd_t                  cmd,
  output rhlc_pkg::rhlc_sts_t                  sts
);

  localparam int SW = rhlc_pkg::SLOT_W;
  localparam int RW = rhlc_pkg::REGION_W;
  localparam int KW = rhlc_pkg::KEY_W;
  localparam int TW = rhlc_pkg::STAMP_BITS;
  localparam int CW = rhlc_pkg::CHUNK_W;

  // Floor division by a power of two is an arithmetic right shift.
  function automatic logic [RW-1:0] region_of(input logic [CW-1:0] c);
    logic signed [CW-1:0] s;
    s = $signed(c) >>> rhlc_pkg::REGION_SHIFT;
    return s[RW-1:0];
  endfunction

  function automatic logic [rhlc_pkg::SLOT_FIELD_W-1:0] slot_field(input logic [SW-1:0] i);
    logic [SW+rhlc_pkg::SLOT_FIELD_W-1:0] w;
    w = {{rhlc_pkg::SLOT_FIELD_W{1'b0}}, i};
    return w[rhlc_pkg::SLOT_FIELD_W-1:0];
  endfunction

  // Slot table.
  logic [rhlc_pkg::SLOTS-1:0] valid_r;
  logic [KW-1:0]              key_r   [rhlc_pkg::SLOTS];
  logic [TW-1:0]              stamp_r [rhlc_pkg::SLOTS];
  logic [TW-1:0]              ctr_r;

  // Request and scan state.
  logic [RW-1:0] rx_r, rz_r;
  logic          opens_r;
  logic [SW-1:0] idx_r;
  logic          hit_r, free_r;
  logic [SW-1:0] hit_idx_r, free_idx_r, vic_idx_r;
  logic [TW-1:0] vic_stamp_r;
  logic [KW-1:0] vic_key_r;
  logic [rhlc_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [KW-1:0] req_key;
  logic [KW-1:0] cur_key;
  logic          cur_valid;
  logic [TW-1:0] cur_stamp;
  logic          take_hit, take_free, take_vic;
  logic [TW-1:0] ctr_inc;
  logic          evict;
  logic [SW-1:0] miss_slot, res_slot;
  logic [RW-1:0] ev_x, ev_z;

  assign req_key   = {rx_r, rz_r};
  assign cur_key   = key_r[idx_r];
  assign cur_valid = valid_r[idx_r];
  assign cur_stamp = stamp_r[idx_r];

  assign take_hit  = cur_valid && (cur_key == req_key) && !hit_r;
  assign take_free = !cur_valid && !free_r;
  // The first slot always seeds the least-stamp search; later ties keep it.
  assign take_vic  = (idx_r == '0) || (cur_stamp < vic_stamp_r);

  assign sts.scan_last = (idx_r == SW'(rhlc_pkg::SLOTS - 1));

  // Saturating increment of the use counter.
  assign ctr_inc   = (ctr_r == {TW{1'b1}}) ? ctr_r : ctr_r + TW'(1);

  assign evict     = !hit_r && !free_r;
  assign miss_slot = free_r ? free_idx_r : vic_idx_r;
  assign res_slot  = hit_r ? hit_idx_r : miss_slot;
  assign ev_x      = evict ? vic_key_r[KW-1:RW] : '0;
  assign ev_z      = evict ? vic_key_r[RW-1:0]  : '0;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rx_r    <= region_of(in_tdata[CW-1:0]);
      rz_r    <= region_of(in_tdata[2*CW-1:CW]);
      opens_r <= in_tdata[2*CW+1];
    end
    if (cmd.step) begin
      if (take_hit) begin
        hit_idx_r <= idx_r;
      end
      if (take_free) begin
        free_idx_r <= idx_r;
      end
      if (take_vic) begin
        vic_idx_r   <= idx_r;
        vic_stamp_r <= cur_stamp;
        vic_key_r   <= cur_key;
      end
    end
    if (cmd.commit) begin
      if (hit_r) begin
        stamp_r[hit_idx_r] <= ctr_inc;
      end else if (opens_r) begin
        key_r[miss_slot]   <= req_key;
        stamp_r[miss_slot] <= ctr_inc;
      end else if (evict) begin
        stamp_r[miss_slot] <= '0;
      end
    end
    if (cmd.load) begin
      out_data_r <= {{rhlc_pkg::OUT_PAD_W{1'b0}}, !hit_r, ev_z, ev_x, evict,
                     rz_r, rx_r, slot_field(res_slot), hit_r, hit_r || opens_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ctr_r   <= TW'(1);
      idx_r   <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.step) begin
        idx_r <= idx_r + SW'(1);
        if (take_hit) begin
          hit_r <= 1'b1;
        end
        if (take_free) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (hit_r) begin
          ctr_r <= ctr_inc;
        end else begin
          valid_r[miss_slot] <= opens_r;
          if (opens_r) begin
            ctr_r <= ctr_inc;
          end
        end
      end
    end
  end

  assign out_tdata = out_data_r;

`ifndef SYNTHESIS
  a_ctr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctr_r != '0)
    else $error("use counter reached zero");

  a_evict_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && evict |-> (&valid_r))
    else $error("eviction chosen while a free slot existed");

  a_hit_slot_stays_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && hit_r |=> valid_r[$past(hit_idx_r)])
    else $error("hit slot lost its valid mark");
`endif

endmodule

FILE: src/region_handle_lru_cache_core.sv
// Region handle LRU cache: top level joining the controller and datapath.
// Depends on rhlc_pkg, rhlc_ctrl and rhlc_dpath.
//
// Each input word carries signed chunk coordinates; they are floor-divided
// by 2^REGION_SHIFT into region coordinates and looked up in a 16-slot fully
// associative table. A hit refreshes the slot's use stamp; a miss takes the
// first empty slot or evicts the least recently used one (lowest slot on a
// tie), reports the evicted region, and fills the slot only if the word says
// the backing open succeeded. Every input word yields exactly one result
// word. The word is captured at the accepting edge, then the slots are
// examined one slot per cycle for the match, free-slot and least-stamp scan
// through the single table read port, then the table is updated, then the
// result is loaded into the output register. The next word can be accepted
// in the cycle in which the result is first offered, even if the previous
// result has not yet been taken; a word accepted that way waits for the
// output register to drain before its own result is loaded. No clearing
// pass is needed after reset.
module region_handle_lru_cache_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: chunk_x[21:0], chunk_z[43:22], create_allowed[44],
  // open_succeeds[45], zero padding.
  input  logic [rhlc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: granted[0], was_hit[1], slot_index[5:2],
  // region_x[22:6], region_z[39:23], evicted[40], evicted_x[57:41],
  // evicted_z[74:58], open_requested[75], zero padding.
  output logic [rhlc_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  rhlc_pkg::rhlc_cmd_t cmd;
  rhlc_pkg::rhlc_sts_t sts;

  rhlc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rhlc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: dv/region_handle_lru_cache_core_checker.sv
`timescale 1ns / 1ps
// Checker for the region handle LRU cache: watches both stream channels, predicts each result
// word from its own copy of the slot table and compares. Depends on rhlc_pkg.
module region_handle_lru_cache_core_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rhlc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rhlc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              hit_count,
  output int                              miss_count,
  output int                              evict_count,
  output int                              refused_count
);
  import rhlc_pkg::*;

  typedef struct packed {
    logic                    granted;
    logic                    was_hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [REGION_W-1:0]     region_x;
    logic [REGION_W-1:0]     region_z;
    logic                    evicted;
    logic [REGION_W-1:0]     evicted_x;
    logic [REGION_W-1:0]     evicted_z;
    logic                    open_requested;
  } handle_reply_t;

  // Shadow copy of the slot table.
  logic                  slot_valid [SLOTS];
  logic [REGION_W-1:0]   slot_rx    [SLOTS];
  logic [REGION_W-1:0]   slot_rz    [SLOTS];
  logic [STAMP_BITS-1:0] slot_stamp [SLOTS];
  logic [STAMP_BITS-1:0] use_count;

  handle_reply_t expected_replies[$];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    hit_count     = 0;
    miss_count    = 0;
    evict_count   = 0;
    refused_count = 0;
  end

  // Floor division by 2^REGION_SHIFT is an arithmetic right shift.
  function automatic logic [REGION_W-1:0] chunk_to_region(logic [CHUNK_W-1:0] c);
    logic signed [CHUNK_W-1:0] s;
    s = c;
    return REGION_W'(s >>> REGION_SHIFT);
  endfunction

  // The counter moves first and sticks at all ones; the new value is the stamp.
  function automatic logic [STAMP_BITS-1:0] advance_use_count();
    if (use_count != '1) use_count = use_count + 1'b1;
    return use_count;
  endfunction

  function automatic handle_reply_t lookup_region(logic [CHUNK_W-1:0] cx,
                                                  logic [CHUNK_W-1:0] cz,
                                                  logic opens);
    handle_reply_t r;
    int slot;
    logic [REGION_W-1:0] rx;
    logic [REGION_W-1:0] rz;
    rx = chunk_to_region(cx);
    rz = chunk_to_region(cz);
    r = '0;
    r.region_x = rx;
    r.region_z = rz;
    slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && slot_valid[i] && slot_rx[i] == rx && slot_rz[i] == rz) slot = i;
    end
    if (slot >= 0) begin
      slot_stamp[slot] = advance_use_count();
      r.granted = 1'b1;
      r.was_hit = 1'b1;
      r.slot    = SLOT_FIELD_W'(slot);
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && !slot_valid[i]) slot = i;
    end
    if (slot < 0) begin
      // Table full: the least stamp goes, lowest slot on a tie.
      slot = 0;
      for (int i = 1; i < SLOTS; i++) begin
        if (slot_stamp[i] < slot_stamp[slot]) slot = i;
      end
      r.evicted   = 1'b1;
      r.evicted_x = slot_rx[slot];
      r.evicted_z = slot_rz[slot];
      slot_valid[slot] = 1'b0;
      slot_rx[slot]    = '0;
      slot_rz[slot]    = '0;
      slot_stamp[slot] = '0;
    end
    if (opens) begin
      slot_valid[slot] = 1'b1;
      slot_rx[slot]    = rx;
      slot_rz[slot]    = rz;
      slot_stamp[slot] = advance_use_count();
    end
    r.granted        = opens;
    r.slot           = SLOT_FIELD_W'(slot);
    r.open_requested = 1'b1;
    return r;
  endfunction

  function automatic string describe(handle_reply_t r);
    return $sformatf("granted=%0d hit=%0d slot=%0d region=(%0d,%0d) evicted=%0d (%0d,%0d) open=%0d",
                     r.granted, r.was_hit, r.slot, $signed(r.region_x), $signed(r.region_z),
                     r.evicted, $signed(r.evicted_x), $signed(r.evicted_z), r.open_requested);
  endfunction

  always @(posedge clk) begin : monitor
    handle_reply_t want;
    handle_reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_rx[i]    = '0;
        slot_rz[i]    = '0;
        slot_stamp[i] = '0;
      end
      use_count = 1;
      expected_replies.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        want = lookup_region(in_tdata[CHUNK_W-1:0], in_tdata[2*CHUNK_W-1:CHUNK_W],
                             in_tdata[2*CHUNK_W+1]);
        expected_replies.push_back(want);
        if (want.was_hit) hit_count <= hit_count + 1;
        else miss_count <= miss_count + 1;
        if (want.evicted) evict_count <= evict_count + 1;
        if (want.open_requested && !want.granted) refused_count <= refused_count + 1;
      end
      if (out_tvalid && out_tready) begin
        got.granted        = out_tdata[0];
        got.was_hit        = out_tdata[1];
        got.slot           = out_tdata[5:2];
        got.region_x       = out_tdata[22:6];
        got.region_z       = out_tdata[39:23];
        got.evicted        = out_tdata[40];
        got.evicted_x      = out_tdata[57:41];
        got.evicted_z      = out_tdata[74:58];
        got.open_requested = out_tdata[75];
        if (expected_replies.size() == 0) begin
          if (fail_count < 10) $display("%t: result word with none expected: %s", $realtime,
                                        describe(got));
          fail_count <= fail_count + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%t: result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

FILE: dv/region_handle_lru_cache_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the region handle LRU cache: drives request words, stalls the result side
// and gives the verdict. Depends on rhlc_pkg, the block and region_handle_lru_cache_core_checker.
module region_handle_lru_cache_core_tb;
  import rhlc_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int POOL_SIZE    = 24;  // more regions than slots, so the LRU choice is exercised
  localparam int HOT_SIZE     = 6;   // a few regions revisited often, so hits are common
  localparam int DRAIN_CYCLES = 60;  // spare time to watch for stray result words

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int hit_count;
  int miss_count;
  int evict_count;
  int refused_count;

  // When set, the sender or the receiver runs without gaps for a stretch of words.
  bit in_rushing  = 1'b0;
  bit out_rushing = 1'b0;

  logic [REGION_W-1:0] pool_x [POOL_SIZE];
  logic [REGION_W-1:0] pool_z [POOL_SIZE];

  region_handle_lru_cache_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  region_handle_lru_cache_core_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .hit_count     (hit_count),
    .miss_count    (miss_count),
    .evict_count   (evict_count),
    .refused_count (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net: a correct run needs well under a quarter of this.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one request word after a random gap and holds it until it is taken. With no gap
  // tvalid simply stays high, so it is never lowered and raised in the same step.
  task automatic send_request(input int cx, input int cz, input bit create, input bit opens);
    int gap;
    gap = in_rushing ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, opens, create,
                  CHUNK_W'(cz), CHUNK_W'(cx)};
    do @(posedge clk); while (!in_tready);
  endtask

  // A chunk inside the given region, with a random offset in the low bits.
  function automatic int chunk_in(logic [REGION_W-1:0] region);
    logic [CHUNK_W-1:0] c;
    c = {region, REGION_SHIFT'($urandom())};
    return int'(c);
  endfunction

  // Result side: a random stall before each word, with stretches of no stalling at all.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken % 40 == 0) out_rushing = ($urandom_range(0, 3) == 0);
      stall = out_rushing ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int pick;
    int idx;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = REGION_W'($urandom());
      pool_z[i] = REGION_W'($urandom());
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First the coordinate extremes and the rounding of negative chunks.
    send_request(0, 0, 1'b1, 1'b1);                  // empty table: miss into slot 0
    send_request(31, 31, 1'b0, 1'b1);                // same region, other corner: hit
    send_request(-1, -1, 1'b1, 1'b0);                // region (-1,-1), open fails
    send_request(-32, -32, 1'b1, 1'b1);              // same region again, now filled
    send_request(-33, -33, 1'b0, 1'b1);              // floors to region (-2,-2)
    send_request(2097151, -2097152, 1'b1, 1'b1);     // largest x, smallest z
    send_request(-2097152, 2097151, 1'b0, 1'b0);     // smallest x, largest z, refused
    send_request(-2097152, 2097151, 1'b1, 1'b1);
    send_request(32, 0, 1'b1, 1'b1);                 // keys differing only in x
    send_request(0, 32, 1'b1, 1'b1);                 // and only in z
    send_request(-1, -1, 1'b0, 1'b1);                // hit on a negative region
    send_request(0, 0, 1'b0, 1'b0);                  // a hit ignores the open outcome
    // Fill the remaining slots, then force evictions of the least recently used entries.
    for (int i = 0; i < 9; i++) send_request((100 + i) * 32 + i, -(200 + i) * 32 - i, 1'b1, 1'b1);
    send_request(5000 * 32, 7 * 32, 1'b1, 1'b1);
    send_request(-5000 * 32, 9 * 32, 1'b0, 1'b0);    // evicts but leaves the slot empty
    send_request(-5000 * 32, 9 * 32, 1'b1, 1'b1);    // refills the freed slot

    // Random part: mostly revisits of a pool of regions larger than the table, so hits,
    // first-free fills and evictions all recur, plus wholly random chunks as noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) in_rushing = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        send_request(chunk_in(pool_x[idx]), chunk_in(pool_z[idx]), 1'($urandom()),
                     $urandom_range(0, 9) != 0);
      end else if (pick < 80) begin
        idx = $urandom_range(0, HOT_SIZE - 1);
        send_request(chunk_in(pool_x[idx]), chunk_in(pool_z[idx]), 1'($urandom()),
                     $urandom_range(0, 9) != 0);
      end else if (pick < 92) begin
        send_request(int'(CHUNK_W'($urandom())), int'(CHUNK_W'($urandom())), 1'($urandom()),
                     1'($urandom()));
      end else begin
        // Retire one pool region in favour of a fresh one.
        idx = $urandom_range(0, POOL_SIZE - 1);
        pool_x[idx] = REGION_W'($urandom());
        pool_z[idx] = REGION_W'($urandom());
        send_request(chunk_in(pool_x[idx]), chunk_in(pool_z[idx]), 1'($urandom()),
                     $urandom_range(0, 3) != 0);
      end
    end
    in_tvalid <= 1'b0;

    // Let every expected word arrive, then watch a while longer for stray words.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d hits, %0d misses, %0d evictions, %0d refused opens.",
             hit_count + miss_count, hit_count, miss_count, evict_count, refused_count);
    $display("Mismatches: %0d, results still owed: %0d.", fail_count, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
